// ===== rtl/can_to_servo_pwm_bridge_defines.svh =====
// Assertion macros shared by the bridge checker
`ifndef CAN_TO_SERVO_PWM_BRIDGE_DEFINES_SVH
`define CAN_TO_SERVO_PWM_BRIDGE_DEFINES_SVH

// Same-cycle implication, reset masked
`define CPSB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpsb assertion failed");

// Next-cycle implication, reset masked
`define CPSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpsb assertion failed");

`endif

// ===== rtl/cpsb_pkg.sv =====
// Package: shared types and constants for the CAN to servo PWM bridge
`default_nettype none

package cpsb_pkg;

    // Default parameter values
    localparam int CHANNEL_COUNT_DEF = 4;
    localparam int DUTY_BITS_DEF     = 16;

    // Input word opcodes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Config register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ID_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ID_C     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd4;

    // Config reset values
    localparam logic [10:0] ID_A_RST     = 11'h123;
    localparam logic [10:0] ID_B_RST     = 11'h1E0;
    localparam logic [10:0] ID_C_RST     = 11'h2F0;
    localparam logic [15:0] SILENCE_RST  = 16'd1000;
    localparam logic [9:0]  PERIOD_RST   = 10'd50;

    // Duty arithmetic: duty = floor(M * x / divisor)
    localparam int X_W     = 17;
    localparam int DEN_W   = 21;
    localparam logic [DEN_W-1:0] CMD_DIVISOR = 21'd1310700;  // 20 * 65535
    localparam logic [DEN_W-1:0] PAT_DIVISOR = 21'd200000;
    localparam logic [X_W-1:0]   CMD_OFFSET  = 17'd65535;

    // Reciprocal divide, sized for M up to 20 bits. The estimate drops the low
    // RCP_SHIFT numerator bits and lands at most two below the true quotient.
    localparam int NUMER_W   = 20 + X_W;
    localparam int RCP_SHIFT = 17;
    localparam int RCP_K     = 38;
    localparam int QUOT_W    = NUMER_W - RCP_SHIFT;
    localparam int PROD_W    = QUOT_W + DEN_W;
    localparam int REM_W     = DEN_W + 2;
    localparam logic [DEN_W-1:0] CMD_RECIP = DEN_W'((64'd1 << RCP_K) / 64'(CMD_DIVISOR));
    localparam logic [DEN_W-1:0] PAT_RECIP = DEN_W'((64'd1 << RCP_K) / 64'(PAT_DIVISOR));

    // Sweep pattern
    localparam int Q_W = 14;
    localparam logic [Q_W-1:0] PAT_FULL  = 14'd10000;
    localparam logic [Q_W-1:0] LEVEL_SCL = 14'd100;
    localparam logic [6:0]     LEVEL_TOP = 7'd100;
    localparam logic [6:0]     LEVEL_MID = 7'd50;
    localparam logic [15:0]    SIL_MAX   = 16'hFFFF;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/cpsb_div.sv =====
// Constant divide on a shared multiplier: reciprocal estimate, then one correction
`default_nettype none

module cpsb_div
    import cpsb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [NUMER_W-1:0] numer,
    input  wire logic [DEN_W-1:0]   denom,
    input  wire logic [DEN_W-1:0]   recip,
    output logic                    done,
    output logic [QUOT_W-1:0]       quot
);

    logic [NUMER_W-1:0] num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rcp_reg;
    logic [QUOT_W-1:0]  qest_reg, qest_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic               est_reg, chk_reg, done_reg;
    logic [QUOT_W-1:0]  mul_a;
    logic [DEN_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod;
    logic [REM_W-1:0]   rem;

    // Shared multiplier: numerator top times reciprocal, then estimate times divisor
    always_comb
    begin
        if (chk_reg)
        begin
            mul_a = qest_reg;
            mul_b = den_reg;
        end
        else
        begin
            mul_a = num_reg[NUMER_W-1:RCP_SHIFT];
            mul_b = rcp_reg;
        end
        prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
        qest_next = prod[PROD_W-1:PROD_W-QUOT_W];
        // remainder of the estimate is below three divisors
        rem       = REM_W'({{(PROD_W-NUMER_W){1'b0}}, num_reg} - prod);
        if (rem >= {1'b0, den_reg, 1'b0})
        begin
            quot_next = qest_reg + QUOT_W'(2);
        end
        else if (rem >= {2'b00, den_reg})
        begin
            quot_next = qest_reg + QUOT_W'(1);
        end
        else
        begin
            quot_next = qest_reg;
        end
    end

    // Phase flags: estimate, check, done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg  <= 1'b0;
            chk_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            est_reg  <= start;
            chk_reg  <= est_reg;
            done_reg <= chk_reg;
        end
    end

    // Operands, estimate and corrected quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rcp_reg <= recip;
        end
        if (est_reg)
        begin
            qest_reg <= qest_next;
        end
        if (chk_reg)
        begin
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/can_to_servo_pwm_bridge.sv =====
// Top level: CAN frames and ms ticks in, servo PWM duty words out
// Words that give no result (ticks, non-command frames) leave the sequencer idle.
// A result passes the load state, then the divider's estimate, check and done
// phases on the two-pass shared multiplier; a sweep step repeats this per channel
// once the result before is taken, and output stalls hold each result word.
// Reset clears timers, fallback, sweep and loads the default config registers.
`default_nettype none

module can_to_servo_pwm_bridge
    import cpsb_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int DUTY_BITS     = DUTY_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input words
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  opcode,
    input  wire logic [28:0]           frame_ident,
    input  wire logic                  extended_frame,
    input  wire logic [3:0]            frame_length,
    input  wire logic [7:0]            channel_byte,
    input  wire logic [7:0]            level_low_byte,
    input  wire logic [7:0]            level_high_byte,
    // result words
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 out_channel,
    output logic [15:0]                duty_value,
    output logic                       last_of_run,
    // config writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PAT_N = (CHANNEL_COUNT < 4) ? CHANNEL_COUNT : 4;
    localparam logic [1:0] PAT_LAST = 2'(PAT_N - 1);

    state_t state_reg, state_next;

    logic [10:0] id_a_reg, id_b_reg, id_c_reg;
    logic [15:0] sil_limit_reg;
    logic [9:0]  period_reg;

    logic [15:0] silence_reg;
    logic        fallback_reg;
    logic [9:0]  pattern_reg;
    logic [6:0]  level_reg;
    logic        falling_reg;
    logic [1:0]  idx_reg;

    logic             is_cmd_reg;
    logic [X_W-1:0]   cmd_x_reg;
    logic [1:0]       cmd_chan_reg;
    logic [15:0]      duty_reg;
    logic [1:0]       chan_reg;
    logic             last_reg;

    logic               in_fire, out_fire;
    logic               id_match, cmd_ok;
    logic [15:0]        sil_inc;
    logic               fb_enter, step_go, emit;
    logic [6:0]         level_step;
    logic               falling_step;
    logic [Q_W-1:0]     q0, q_sel;
    logic [X_W-1:0]     x_sel;
    logic [NUMER_W-1:0] numer;
    logic [DEN_W-1:0]   denom;
    logic [DEN_W-1:0]   recip;
    logic               div_start, div_done;
    logic [QUOT_W-1:0]  quot;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // Command frame decode
    always_comb
    begin
        id_match = (frame_ident == {18'd0, id_a_reg}) ||
                   (frame_ident == {18'd0, id_b_reg}) ||
                   (frame_ident == {18'd0, id_c_reg});
        cmd_ok   = !extended_frame && id_match && (frame_length >= 4'd3) &&
                   (channel_byte < 8'(CHANNEL_COUNT));
    end

    // Tick: silence count, fallback entry and sweep step
    always_comb
    begin
        sil_inc  = (silence_reg != SIL_MAX) ? silence_reg + 16'd1 : silence_reg;
        fb_enter = !fallback_reg && (sil_inc > sil_limit_reg);
        step_go  = fallback_reg && (pattern_reg >= period_reg);
        if (falling_reg)
        begin
            level_step = (level_reg != 7'd0) ? level_reg - 7'd1 : level_reg;
        end
        else
        begin
            level_step = (level_reg < LEVEL_TOP) ? level_reg + 7'd1 : level_reg;
        end
        falling_step = ((level_step >= LEVEL_TOP) || (level_step == 7'd0)) ?
                       !falling_reg : falling_reg;
        emit = (opcode == OP_FRAME) ? cmd_ok : step_go;
    end

    // Pattern value for the current channel and divider operands
    always_comb
    begin
        q0 = Q_W'(level_reg) * LEVEL_SCL;
        case (idx_reg)
            2'd0:    q_sel = q0;
            2'd1:    q_sel = PAT_FULL - q0;
            2'd2:    q_sel = (level_reg < LEVEL_MID) ? '0 : PAT_FULL;
            default: q_sel = Q_W'(level_reg) * Q_W'(level_reg);
        endcase
        x_sel = is_cmd_reg ? cmd_x_reg : X_W'(PAT_FULL) + X_W'(q_sel);
        numer = (NUMER_W'(x_sel) << DUTY_BITS) - NUMER_W'(x_sel);
        denom = is_cmd_reg ? CMD_DIVISOR : PAT_DIVISOR;
        recip = is_cmd_reg ? CMD_RECIP : PAT_RECIP;
    end

    cpsb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (numer),
        .denom (denom),
        .recip (recip),
        .done  (div_done),
        .quot  (quot)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && emit)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = last_reg ? ST_IDLE : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready  = 1'b1;
            ST_LOAD: div_start = 1'b1;
            ST_DIV:  ;
            ST_OUT:  out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_a_reg      <= ID_A_RST;
            id_b_reg      <= ID_B_RST;
            id_c_reg      <= ID_C_RST;
            sil_limit_reg <= SILENCE_RST;
            period_reg    <= PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ID_A:    id_a_reg      <= cfg_data[10:0];
                REG_ID_B:    id_b_reg      <= cfg_data[10:0];
                REG_ID_C:    id_c_reg      <= cfg_data[10:0];
                REG_SILENCE: sil_limit_reg <= cfg_data;
                REG_PERIOD:  period_reg    <= cfg_data[9:0];
                default:     ;
            endcase
        end
    end

    // Silence timer, fallback and sweep state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_reg  <= '0;
            fallback_reg <= 1'b0;
            pattern_reg  <= '0;
            level_reg    <= '0;
            falling_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            if (opcode == OP_FRAME)
            begin
                silence_reg  <= '0;
                fallback_reg <= 1'b0;
            end
            else
            begin
                silence_reg <= sil_inc;
                if (!fallback_reg)
                begin
                    if (fb_enter)
                    begin
                        fallback_reg <= 1'b1;
                        pattern_reg  <= '0;
                    end
                end
                else if (!step_go)
                begin
                    pattern_reg <= pattern_reg + 10'd1;
                end
                else
                begin
                    pattern_reg <= '0;
                    level_reg   <= level_step;
                    falling_reg <= falling_step;
                end
            end
        end
    end

    // Channel index within a sweep run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (in_fire)
        begin
            idx_reg <= '0;
        end
        else if (out_fire)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Captured command operands
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            is_cmd_reg   <= (opcode == OP_FRAME);
            cmd_x_reg    <= X_W'({level_high_byte, level_low_byte}) + CMD_OFFSET;
            cmd_chan_reg <= channel_byte[1:0];
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DIV) && div_done)
        begin
            duty_reg <= quot[15:0];
            chan_reg <= is_cmd_reg ? cmd_chan_reg : idx_reg;
            last_reg <= is_cmd_reg || (idx_reg == PAT_LAST);
        end
    end

    assign out_channel = chan_reg;
    assign duty_value  = duty_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

// ===== rtl/cpsb_chk.sv =====
// Port-level checker for the bridge, bound to the top level
`default_nettype none

`include "can_to_servo_pwm_bridge_defines.svh"

module cpsb_chk
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  out_channel,
    input wire logic [15:0] duty_value,
    input wire logic        last_of_run
);

    // Stalled result word holds
    `CPSB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(duty_value) && $stable(out_channel) && $stable(last_of_run))

    // No new word taken while a result is pending
    `CPSB_ASSERT_NOW(a_busy_excl, clk, rst_n, out_valid, !in_ready)

    // A run that is not finished keeps the input closed
    `CPSB_ASSERT_NEXT(a_run_cont, clk, rst_n, out_valid && out_ready && !last_of_run, !in_ready)

    // A run closes on a command word or the last sweep channel, so non-last words never name channel 3
    `CPSB_ASSERT_NOW(a_mid_chan, clk, rst_n, out_valid && !last_of_run, out_channel != 2'd3)

endmodule

bind can_to_servo_pwm_bridge cpsb_chk u_cpsb_chk (.*);

`default_nettype wire
